// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int BURST_BITS = 16;

    localparam int SLOT_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int TIME_W  = 20;
    localparam int SUM_W   = 24;
    localparam int QUANT_W = 16;
    localparam int JOB_W   = 4;
    localparam int IN_W    = 16;
    localparam int LEFT_W  = 16;
    localparam int ALU_W   = (BURST_BITS > SUM_W) ? BURST_BITS : SUM_W;

    localparam int OP_W     = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 152;

    // result word layout, lowest bit first
    localparam int M_JOB_LO   = 0;
    localparam int M_START_LO = M_JOB_LO + JOB_W;
    localparam int M_END_LO   = M_START_LO + TIME_W;
    localparam int M_LEFT_LO  = M_END_LO + TIME_W;
    localparam int M_FIN_BIT  = M_LEFT_LO + LEFT_W;
    localparam int M_WAIT_LO  = M_FIN_BIT + 1;
    localparam int M_TURN_LO  = M_WAIT_LO + TIME_W;
    localparam int M_TWAIT_LO = M_TURN_LO + TIME_W;
    localparam int M_TTURN_LO = M_TWAIT_LO + SUM_W;
    localparam int M_USED_W   = M_TTURN_LO + SUM_W;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REM,
        ST_CMP,
        ST_FIN,
        ST_WAIT,
        ST_WSUM,
        ST_TSUM,
        ST_SRV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic served_we;
        logic retire;
    } jobs_ctrl_t;

endpackage

// ----- rtl/rrts_alu.sv -----
module rrts_alu (
    input  logic [rrts_pkg::ALU_W-1:0] op_a,
    input  logic [rrts_pkg::ALU_W-1:0] op_b,
    input  logic                       sub,
    output logic [rrts_pkg::ALU_W-1:0] res,
    output logic                       carry
);
    import rrts_pkg::*;

    logic [ALU_W:0] sum;

    // subtract as a plus not b plus one; carry high means no borrow
    assign sum   = {1'b0, op_a} + {1'b0, op_b ^ {ALU_W{sub}}} + (ALU_W + 1)'(sub);
    assign res   = sum[ALU_W-1:0];
    assign carry = sum[ALU_W];

endmodule

// ----- rtl/rrts_jobs.sv -----
module rrts_jobs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rrts_pkg::jobs_ctrl_t            ctrl,
    input  logic [rrts_pkg::SLOT_W-1:0]     wr_slot,
    input  logic [rrts_pkg::BURST_BITS-1:0] load_burst,
    input  logic [rrts_pkg::BURST_BITS-1:0] served_data,
    input  logic [rrts_pkg::SLOT_W-1:0]     rd_slot,
    output logic [rrts_pkg::BURST_BITS-1:0] rd_burst,
    output logic [rrts_pkg::BURST_BITS-1:0] rd_served,
    output logic                            rd_active
);
    import rrts_pkg::*;

    logic [BURST_BITS-1:0] burst_reg  [MAX_JOBS];
    logic [BURST_BITS-1:0] served_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0]   active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (ctrl.clear) begin
            active_reg <= '0;
        end else begin
            if (ctrl.load) begin
                active_reg[wr_slot] <= 1'b1;
            end
            if (ctrl.retire) begin
                active_reg[rd_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            burst_reg[wr_slot]  <= load_burst;
            served_reg[wr_slot] <= '0;
        end else if (ctrl.served_we) begin
            served_reg[rd_slot] <= served_data;
        end
    end

    assign rd_burst  = burst_reg[rd_slot];
    assign rd_served = served_reg[rd_slot];
    assign rd_active = active_reg[rd_slot];

endmodule

// ----- rtl/round_robin_time_slice_scheduler.sv -----
// Round-robin time-slice scheduler over a small job table.
//
// Input channel s_*: s_tuser carries the operation (load, step, clear) and
// s_tdata the burst length for a load. Loads append a job (ignored when the
// table is full), clear empties the table and zeroes time and totals; neither
// produces a result. A step hands one slice to the next unfinished job after
// the last one served and produces exactly one result on m_*, with
// m_tuser high when no unfinished job remains.
// Loads and clears complete in the idle state. A step searches past inactive
// slots (at most the job count), then runs remainder, compare, finish, wait,
// wait sum and turnaround sum for a slice that completes its job, or remainder,
// compare, finish and served for one that does not, all on the one shared adder.
// The block takes one transaction at a time; s_tready stays low from a step
// until its result has been taken, so a stalled m_tready simply holds the
// result and the input side. cfg_wr_en writes the quantum (zero acts as one)
// and should only be used while idle. Reset empties the table, zeroes time
// and totals and sets the quantum to 4.
module round_robin_time_slice_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rrts_pkg::QUANT_W-1:0]  cfg_wr_data,  // time_quantum
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrts_pkg::S_DATA_W-1:0] s_tdata,      // burst_length
    input  logic [rrts_pkg::OP_W-1:0]     s_tuser,      // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // job_index, slice_start, slice_end, time_left, job_finished, wait_time,
    // turnaround_time, total_wait, total_turnaround, zero pad
    output logic [rrts_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser       // all_done
);
    import rrts_pkg::*;

    state_t state_reg, state_next;

    logic [QUANT_W-1:0] quantum_reg;
    logic [CNT_W-1:0]   job_count_reg;
    logic [SLOT_W-1:0]  next_slot_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SUM_W-1:0]   wsum_reg;
    logic [SUM_W-1:0]   tsum_reg;

    logic [SLOT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [BURST_BITS-1:0] rem_reg;
    logic [BURST_BITS-1:0] left_reg;
    logic [ALU_W-1:0]      slice_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [TIME_W-1:0]     start_reg;
    logic [TIME_W-1:0]     finish_reg;
    logic [TIME_W-1:0]     wait_reg;

    logic                  accept;
    logic [QUANT_W-1:0]    q_eff;
    logic [SLOT_W-1:0]     start_slot;
    logic [SLOT_W-1:0]     ptr_wrap;
    logic                  last_slot;
    logic                  longer;

    jobs_ctrl_t            jctrl;
    logic [BURST_BITS-1:0] served_data;
    logic [BURST_BITS-1:0] rd_burst;
    logic [BURST_BITS-1:0] rd_served;
    logic                  rd_active;

    logic [ALU_W-1:0]      alu_a;
    logic [ALU_W-1:0]      alu_b;
    logic                  alu_sub;
    logic [ALU_W-1:0]      alu_res;
    logic                  alu_carry;

    logic [M_USED_W-1:0]   result;

    assign accept     = s_tvalid && s_tready;
    assign q_eff      = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign start_slot = (CNT_W'(next_slot_reg) < job_count_reg) ? next_slot_reg : '0;
    assign last_slot  = (CNT_W'(ptr_reg) + CNT_W'(1)) >= job_count_reg;
    assign ptr_wrap   = last_slot ? '0 : ptr_reg + SLOT_W'(1);
    // remaining time exceeds the quantum: no borrow and a non-zero difference
    assign longer     = alu_carry && (alu_res != '0);

    rrts_jobs u_jobs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (jctrl),
        .wr_slot     (job_count_reg[SLOT_W-1:0]),
        .load_burst  (BURST_BITS'(s_tdata)),
        .served_data (served_data),
        .rd_slot     (ptr_reg),
        .rd_burst    (rd_burst),
        .rd_served   (rd_served),
        .rd_active   (rd_active)
    );

    rrts_alu u_alu (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        jctrl       = '0;
        served_data = rd_burst;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    unique case (s_tuser)
                        OP_LOAD:  jctrl.load = (job_count_reg < CNT_W'(MAX_JOBS));
                        OP_STEP:  state_next = ST_SEARCH;
                        OP_CLEAR: jctrl.clear = 1'b1;
                        default:  ;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (k_reg == job_count_reg) begin
                    state_next = ST_OUT;
                end else if (rd_active) begin
                    state_next = ST_REM;
                end
            end
            ST_REM: begin
                alu_a      = ALU_W'(rd_burst);
                alu_b      = ALU_W'(rd_served);
                alu_sub    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                alu_a      = ALU_W'(rem_reg);
                alu_b      = ALU_W'(q_eff);
                alu_sub    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                alu_a      = ALU_W'(time_reg);
                alu_b      = slice_reg;
                state_next = fin_reg ? ST_WAIT : ST_SRV;
            end
            ST_WAIT: begin
                alu_a      = ALU_W'(finish_reg);
                alu_b      = ALU_W'(rd_burst);
                alu_sub    = 1'b1;
                state_next = ST_WSUM;
            end
            ST_WSUM: begin
                alu_a      = ALU_W'(wsum_reg);
                alu_b      = ALU_W'(wait_reg);
                state_next = ST_TSUM;
            end
            ST_TSUM: begin
                alu_a           = ALU_W'(tsum_reg);
                alu_b           = ALU_W'(finish_reg);
                jctrl.served_we = 1'b1;
                jctrl.retire    = 1'b1;
                served_data     = rd_burst;
                state_next      = ST_OUT;
            end
            ST_SRV: begin
                alu_a           = ALU_W'(rd_served);
                alu_b           = ALU_W'(q_eff);
                jctrl.served_we = 1'b1;
                served_data     = alu_res[BURST_BITS-1:0];
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // scheduler state that reset puts back, and clear too apart from the quantum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg   <= QUANT_RESET;
            job_count_reg <= '0;
            next_slot_reg <= '0;
            time_reg      <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            if (jctrl.clear) begin
                job_count_reg <= '0;
                next_slot_reg <= '0;
                time_reg      <= '0;
                wsum_reg      <= '0;
                tsum_reg      <= '0;
            end else if (jctrl.load) begin
                job_count_reg <= job_count_reg + CNT_W'(1);
            end
            if (state_reg == ST_FIN) begin
                time_reg      <= alu_res[TIME_W-1:0];
                next_slot_reg <= ptr_wrap;
            end
            if (state_reg == ST_WSUM) begin
                wsum_reg <= alu_res[SUM_W-1:0];
            end
            if (state_reg == ST_TSUM) begin
                tsum_reg <= alu_res[SUM_W-1:0];
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ptr_reg  <= start_slot;
                k_reg    <= '0;
                done_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end
            ST_SEARCH: begin
                if (k_reg == job_count_reg) begin
                    done_reg <= 1'b1;
                end else if (!rd_active) begin
                    ptr_reg <= ptr_wrap;
                    k_reg   <= k_reg + CNT_W'(1);
                end
            end
            ST_REM: rem_reg <= alu_res[BURST_BITS-1:0];
            ST_CMP: begin
                fin_reg   <= !longer;
                slice_reg <= longer ? ALU_W'(q_eff) : ALU_W'(rem_reg);
                left_reg  <= longer ? alu_res[BURST_BITS-1:0] : '0;
            end
            ST_FIN: begin
                start_reg  <= time_reg;
                finish_reg <= alu_res[TIME_W-1:0];
            end
            // a finish earlier than the burst gives no wait
            ST_WAIT: wait_reg <= alu_carry ? alu_res[TIME_W-1:0] : '0;
            default: ;
        endcase
    end

    assign result = {tsum_reg,
                     wsum_reg,
                     fin_reg ? finish_reg : TIME_W'(0),
                     fin_reg ? wait_reg : TIME_W'(0),
                     fin_reg,
                     LEFT_W'(left_reg),
                     finish_reg,
                     start_reg,
                     JOB_W'(ptr_reg)};

    assign m_tdata = done_reg ? '0 : M_DATA_W'(result);
    assign m_tuser = done_reg;

endmodule

// ----- rtl/rrts_checker.sv -----
module rrts_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rrts_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import rrts_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one transaction at a time: no input taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // no result is presented in the cycle after any acceptance; a step searches first
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result in the cycle after acceptance");

    // all-done result carries nothing else
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("all-done result with non-zero fields");

    // a completed job has no time left and turnaround equals the slice end
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[M_FIN_BIT] |->
            m_tdata[M_FIN_BIT-1:M_LEFT_LO] == '0 &&
            m_tdata[M_TWAIT_LO-1:M_TURN_LO] == m_tdata[M_LEFT_LO-1:M_END_LO])
        else $error("inconsistent completion fields");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);
